FILE: rtl/soafir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package soafir_pkg;

	localparam int CHUNK_LEN = 64;
	localparam int TAP_COUNT = 32;
	localparam int TAIL_LEN  = TAP_COUNT - 1;

	localparam int KW      = $clog2(TAP_COUNT);
	localparam int JW      = $clog2(TAP_COUNT);
	localparam int POS_W   = $clog2(CHUNK_LEN);
	localparam int BW      = $clog2(CHUNK_LEN + TAP_COUNT);
	localparam int KADDR_W = $clog2(2 * TAP_COUNT);
	localparam int TADDR_W = $clog2(2 * TAIL_LEN);
	localparam int ACC_W   = 32 + KW;

	localparam logic CMD_TAP    = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// floor shift by 15, then clamp to 16 bits
	function automatic logic signed [15:0] shift_sat(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-16:0] q;
		q = a[ACC_W-1:15];
		if (!q[ACC_W-16] && (|q[ACC_W-16:15]))
			return 16'sh7FFF;
		if (q[ACC_W-16] && !(&q[ACC_W-16:15]))
			return -16'sh8000;
		return q[15:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/stereo_overlap_add_fir_q15.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   valid         stall         payload
// item      item_valid    item_stall    cmd, channel, tap_index, value
// result    result_valid  result_stall  left_out, right_out, chunk_end
//
// Each sample is computed by the one shared multiply-accumulate fed from the
// kernel and history memories, one read each per cycle. The last sample of a
// chunk adds a tail pass per channel on the same unit.
// Reset clears kernel valid bits and the tail-valid flag; no clearing pass.
// The output register lets a new word in while a result waits; a stalled result
// holds the block only when the next result is ready to be written.

module stereo_overlap_add_fir_q15 import soafir_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               cmd,
	input  logic               channel,
	input  logic [4:0]         tap_index,
	input  logic signed [15:0] value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [14:0] left_out,
	output logic signed [14:0] right_out,
	output logic               chunk_end
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_OUT} state_t;
	typedef enum logic {MODE_SAMPLE, MODE_TAIL} mode_t;

	state_t               state_q;
	mode_t                mode_q;
	logic                 ch_q;
	logic [KW-1:0]        k_q;
	logic [KW-1:0]        k_hi_q;
	logic [JW-1:0]        j_q;
	logic [BW-1:0]        base_q;
	logic [POS_W-1:0]     pos_q;
	logic                 tail_ok_q;
	logic signed [15:0]   res_l_q;
	logic signed [15:0]   res_r_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                 done_q;

	logic signed [15:0]   kern_mem [2*TAP_COUNT];
	logic [2*TAP_COUNT-1:0] kval_q;
	logic signed [15:0]   hist_mem [CHUNK_LEN];
	logic signed [15:0]   tail_mem [2*TAIL_LEN];
	logic signed [15:0]   tail_rd_q;

	logic signed [15:0]   kd_s1, hd_s1;
	logic                 kv_s1, v_s1, last_s1;
	logic signed [31:0]   prod_s2;
	logic                 v_s2, last_s2;

	logic                 item_take, issue, out_free, last_pos, pos_in_tail, j_last;
	logic                 tail_rd_en, tail_we, acc_hold;
	logic [KADDR_W-1:0]   kern_raddr, kern_waddr;
	logic [POS_W-1:0]     hist_raddr;
	logic [TADDR_W-1:0]   tail_raddr, tail_waddr;
	logic signed [15:0]   sat, mixed;
	logic [JW-1:0]        j_nxt;
	logic [KW-1:0]        samp_hi;

	function automatic logic [KW-1:0] tail_hi(input logic [JW-1:0] j);
		if (int'(j) + CHUNK_LEN < TAP_COUNT - 1)
			return KW'(int'(j) + CHUNK_LEN);
		return KW'(TAP_COUNT - 1);
	endfunction

	assign item_stall  = (state_q != ST_IDLE);
	assign item_take   = item_valid && !item_stall;
	assign issue       = (state_q == ST_RUN);
	assign out_free    = !result_valid || !result_stall;
	assign last_pos    = (int'(pos_q) == CHUNK_LEN - 1);
	assign pos_in_tail = (int'(pos_q) < TAIL_LEN);
	assign j_last      = (int'(j_q) == TAIL_LEN - 1);
	assign j_nxt       = j_last ? '0 : j_q + JW'(1);
	assign samp_hi     = (int'(pos_q) < TAP_COUNT - 1) ? KW'(pos_q) : KW'(TAP_COUNT - 1);

	assign kern_raddr = KADDR_W'(int'(k_q) + (ch_q ? TAP_COUNT : 0));
	assign kern_waddr = KADDR_W'(int'(tap_index) + (channel ? TAP_COUNT : 0));
	assign hist_raddr = POS_W'(base_q - BW'(k_q));
	assign tail_raddr = TADDR_W'(int'(pos_q) + (ch_q ? TAIL_LEN : 0));
	assign tail_waddr = TADDR_W'(int'(j_q) + (ch_q ? TAIL_LEN : 0));
	assign tail_rd_en = issue && (mode_q == MODE_SAMPLE) && pos_in_tail;
	assign tail_we    = (state_q == ST_WAIT) && done_q && (mode_q == MODE_TAIL);
	assign acc_hold   = issue || ((state_q == ST_WAIT) && !done_q);

	assign sat   = shift_sat(acc_q);
	assign mixed = (pos_in_tail && tail_ok_q) ? sat + tail_rd_q : sat;

	// memories
	always_ff @(posedge clk) begin
		if (item_take && cmd == CMD_TAP && int'(tap_index) < TAP_COUNT)
			kern_mem[kern_waddr] <= value;
		if (item_take && cmd == CMD_SAMPLE)
			hist_mem[pos_q] <= value;
		if (tail_we)
			tail_mem[tail_waddr] <= sat;
		kd_s1   <= kern_mem[kern_raddr];
		hd_s1   <= hist_mem[hist_raddr];
		prod_s2 <= (kv_s1 ? kd_s1 : 16'sd0) * hd_s1;
		if (tail_rd_en)
			tail_rd_q <= tail_mem[tail_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kval_q <= '0;
		end else if (item_take && cmd == CMD_TAP && int'(tap_index) < TAP_COUNT) begin
			kval_q[kern_waddr] <= 1'b1;
		end
	end

	// MAC pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_s1   <= 1'b0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			kv_s1   <= kval_q[kern_raddr];
			v_s1    <= issue;
			last_s1 <= issue && (k_q == k_hi_q);
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
			done_q  <= v_s2 && last_s2;
			if (!acc_hold)
				acc_q <= '0;
			else if (v_s2)
				acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_SAMPLE;
			ch_q         <= 1'b0;
			k_q          <= '0;
			k_hi_q       <= '0;
			j_q          <= '0;
			base_q       <= '0;
			pos_q        <= '0;
			tail_ok_q    <= 1'b0;
			res_l_q      <= '0;
			res_r_q      <= '0;
			result_valid <= 1'b0;
			left_out     <= '0;
			right_out    <= '0;
			chunk_end    <= 1'b0;
		end else begin
			if (result_valid && !result_stall && state_q != ST_OUT)
				result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_take && cmd == CMD_SAMPLE) begin
						mode_q  <= MODE_SAMPLE;
						ch_q    <= 1'b0;
						k_q     <= '0;
						k_hi_q  <= samp_hi;
						base_q  <= BW'(pos_q);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_q == k_hi_q)
						state_q <= ST_WAIT;
					else
						k_q <= k_q + KW'(1);
				end
				ST_WAIT: begin
					if (done_q) begin
						if (mode_q == MODE_SAMPLE) begin
							if (!ch_q) begin
								res_l_q <= mixed;
								ch_q    <= 1'b1;
								k_q     <= '0;
								state_q <= ST_RUN;
							end else begin
								res_r_q <= mixed;
								state_q <= ST_OUT;
							end
						end else if (j_last && ch_q) begin
							tail_ok_q <= 1'b1;
							pos_q     <= '0;
							mode_q    <= MODE_SAMPLE;
							state_q   <= ST_IDLE;
						end else begin
							if (j_last)
								ch_q <= 1'b1;
							j_q     <= j_nxt;
							k_q     <= KW'(int'(j_nxt) + 1);
							k_hi_q  <= tail_hi(j_nxt);
							base_q  <= BW'(CHUNK_LEN + int'(j_nxt));
							state_q <= ST_RUN;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						result_valid <= 1'b1;
						left_out     <= res_l_q[15:1];
						right_out    <= res_r_q[15:1];
						chunk_end    <= last_pos;
						if (last_pos) begin
							// chunk done: build the tail sums for the next chunk
							mode_q  <= MODE_TAIL;
							ch_q    <= 1'b0;
							j_q     <= '0;
							k_q     <= KW'(1);
							k_hi_q  <= tail_hi('0);
							base_q  <= BW'(CHUNK_LEN);
							state_q <= ST_RUN;
						end else begin
							pos_q   <= pos_q + POS_W'(1);
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_WAIT)
		else $error("accumulate done outside wait state");

	a_hist_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (base_q >= BW'(k_q)) && (int'(base_q - BW'(k_q)) < CHUNK_LEN))
		else $error("history read outside chunk");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> k_q <= k_hi_q)
		else $error("tap counter past its limit");

	a_tail_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free && last_pos) |=>
			(state_q == ST_RUN && mode_q == MODE_TAIL))
		else $error("chunk end did not start tail pass");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !v_s1 && !v_s2)
		else $error("MAC pipeline busy while idle");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import soafir_pkg::*;

	typedef struct packed {
		logic signed [14:0] left;
		logic signed [14:0] right;
		logic               last;
	} stereo_word_t;

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_SMALL} kern_fill_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	logic               cmd          = CMD_TAP;
	logic               channel      = 1'b0;
	logic [4:0]         tap_index    = '0;
	logic signed [15:0] value        = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [14:0] left_out;
	logic signed [14:0] right_out;
	logic               chunk_end;

	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int errors     = 0;

	stereo_word_t pending_pairs[$];

	// predictor state
	logic signed [15:0] kern      [2][TAP_COUNT];
	logic signed [15:0] hist_now  [TAIL_LEN];
	logic signed [15:0] hist_prev [TAIL_LEN];
	logic signed [15:0] tail_mem  [2][TAIL_LEN];
	int                 pos_m;

	stereo_overlap_add_fir_q15 DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.channel      (channel),
		.tap_index    (tap_index),
		.value        (value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.left_out     (left_out),
		.right_out    (right_out),
		.chunk_end    (chunk_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_model();
		foreach (kern[c, k]) kern[c][k] = '0;
		foreach (tail_mem[c, j]) tail_mem[c][j] = '0;
		foreach (hist_now[k]) begin
			hist_now[k]  = '0;
			hist_prev[k] = '0;
		end
		pos_m = 0;
	endfunction

	// floor shift by 15, clamp to int16
	function automatic logic signed [15:0] clamp_q15(input longint acc);
		longint q;
		q = acc >>> 15;
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic void load_tap(input logic ch, input logic [4:0] ti,
			input logic signed [15:0] v);
		if (ti < TAP_COUNT)
			kern[ch][ti] = v;
	endfunction

	function automatic stereo_word_t convolve_sample(input logic signed [15:0] v);
		stereo_word_t       w;
		longint             acc;
		logic signed [15:0] s;
		logic signed [15:0] y [2];
		for (int ch = 0; ch < 2; ch++) begin
			acc = longint'(kern[ch][0]) * longint'(v);
			for (int k = 1; k < TAP_COUNT && k <= pos_m; k++)
				acc += longint'(kern[ch][k]) * longint'(hist_now[k-1]);
			s = clamp_q15(acc);
			// overlap from previous chunk, 16-bit wrap
			if (pos_m < TAIL_LEN)
				s = s + tail_mem[ch][pos_m];
			y[ch] = s >>> 1;
		end
		w.left  = y[0][14:0];
		w.right = y[1][14:0];
		for (int k = TAIL_LEN - 1; k > 0; k--)
			hist_now[k] = hist_now[k-1];
		hist_now[0] = v;
		w.last = 1'b0;
		if (pos_m >= CHUNK_LEN - 1) begin
			hist_prev = hist_now;
			for (int ch = 0; ch < 2; ch++) begin
				for (int j = 0; j < TAIL_LEN; j++) begin
					acc = 0;
					for (int k = j + 1; k < TAP_COUNT; k++)
						if (k - j - 1 < CHUNK_LEN)
							acc += longint'(kern[ch][k]) * longint'(hist_prev[k-j-1]);
					tail_mem[ch][j] = clamp_q15(acc);
				end
			end
			foreach (hist_now[k]) hist_now[k] = '0;
			pos_m  = 0;
			w.last = 1'b1;
		end else begin
			pos_m++;
		end
		return w;
	endfunction

	function automatic logic signed [15:0] rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 16'($urandom);
		if (pick < 8)
			return 16'(int'($urandom_range(0, 511)) - 256);
		return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
	endfunction

	// one word on the item channel; prediction happens at the accepting edge
	task automatic send_word(input logic c, input logic ch, input logic [4:0] ti,
			input logic signed [15:0] v);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		channel    <= ch;
		tap_index  <= ti;
		value      <= v;
		do @(negedge clk); while (item_stall);
		@(posedge clk);
		if (c == CMD_SAMPLE)
			pending_pairs.push_back(convolve_sample(v));
		else
			load_tap(ch, ti, v);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending_pairs.size() != 0);
		@(posedge clk);
	endtask

	task automatic load_kernel(input logic ch, input kern_fill_t fill);
		int                 first;
		logic signed [15:0] v;
		first = $urandom_range(0, TAP_COUNT - 1);
		for (int i = 0; i < TAP_COUNT; i++) begin
			case (fill)
				FILL_MAX:   v = 16'sh7FFF;
				FILL_MIN:   v = 16'sh8000;
				FILL_SMALL: v = 16'(int'($urandom_range(0, 2047)) - 1024);
				default:    v = 16'($urandom);
			endcase
			send_word(CMD_TAP, ch, 5'((first + i) % TAP_COUNT), v);
		end
	endtask

	// mostly samples, with the odd tap rewrite landing mid-chunk
	task automatic stream_items(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(CMD_TAP, 1'($urandom), 5'($urandom), 16'($urandom));
			else
				send_word(CMD_SAMPLE, 1'($urandom), 5'($urandom), rand_sample());
		end
	endtask

	task automatic test_directed();
		// kernels still zero after reset
		send_word(CMD_SAMPLE, 1'b0, 5'd0, 16'sh7FFF);
		send_word(CMD_SAMPLE, 1'b1, 5'd31, 16'sh8000);
		send_word(CMD_TAP, 1'b0, 5'd0, 16'sh8000);
		send_word(CMD_TAP, 1'b0, 5'd31, 16'sh7FFF);
		send_word(CMD_TAP, 1'b1, 5'd0, 16'sh7FFF);
		send_word(CMD_TAP, 1'b1, 5'd1, 16'sh8000);
		// min * min overflows the positive rail; channel/tap fields are don't-care
		send_word(CMD_SAMPLE, 1'b1, 5'd31, 16'sh8000);
		send_word(CMD_SAMPLE, 1'b0, 5'd17, 16'sh8000);
		send_word(CMD_SAMPLE, 1'b1, 5'd0, 16'sh7FFF);
		send_word(CMD_SAMPLE, 1'b0, 5'd0, 16'sh0000);
		// tap rewrite mid-chunk takes effect on the next sample
		send_word(CMD_TAP, 1'b1, 5'd2, 16'sh4000);
		send_word(CMD_SAMPLE, 1'b1, 5'd10, 16'sh7FFF);
		send_word(CMD_SAMPLE, 1'b0, 5'd21, 16'sh0001);
		send_word(CMD_SAMPLE, 1'b1, 5'd5, 16'shFFFF);
	endtask

	task automatic test_saturating_kernels();
		load_kernel(1'b0, FILL_MAX);
		load_kernel(1'b1, FILL_MIN);
		for (int i = 0; i < 80; i++)
			send_word(CMD_SAMPLE, 1'($urandom), 5'($urandom),
				($urandom_range(0, 3) != 0) ? 16'sh7FFF : 16'sh8000);
	endtask

	task automatic test_random_stream(input kern_fill_t fill, input int n);
		load_kernel(1'b0, fill);
		load_kernel(1'b1, fill);
		stream_items(n);
	endtask

	task automatic test_pause_drain();
		stream_items(60);
		drain_results();
		stream_items(60);
	endtask

	task automatic test_back_to_back(input int n);
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		stream_items(n);
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// result side: draw a stall length per word, then take it
	initial begin : result_sink
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = rx_gaps_on ? $urandom_range(0, 14) : 0;
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(negedge clk); while (!result_valid);
			@(posedge clk);
		end
	end

	always @(negedge clk) begin : check_words
		stereo_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_pairs.size() == 0) begin
				$error("unexpected word: left_out=%0d right_out=%0d chunk_end=%0b",
					left_out, right_out, chunk_end);
				errors++;
			end else begin
				want = pending_pairs.pop_front();
				if (left_out !== want.left) begin
					$error("left_out: expected %0d, got %0d", want.left, left_out);
					errors++;
				end
				if (right_out !== want.right) begin
					$error("right_out: expected %0d, got %0d", want.right, right_out);
					errors++;
				end
				if (chunk_end !== want.last) begin
					$error("chunk_end: expected %0b, got %0b", want.last, chunk_end);
					errors++;
				end
			end
		end
	end

	initial begin
		clear_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturating_kernels();
		test_random_stream(FILL_RANDOM, 700);
		test_pause_drain();
		test_back_to_back(200);
		test_random_stream(FILL_SMALL, 150);
		drain_results();
		// let a trailing tail pass finish before closing
		repeat (1500) @(posedge clk);
		if (errors == 0)
			$display("** stereo_overlap_add_fir_q15: PASSED **");
		else
			$display("** stereo_overlap_add_fir_q15: FAILED **");
		$finish;
	end

	initial begin
		#4000000;
		$display("** stereo_overlap_add_fir_q15: FAILED **");
		$finish;
	end

endmodule
